FILE: rtl/core/trzb_pkg.sv
package trzb_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int CoordW     = 8;
  localparam int AddrW      = 16;
  localparam int DepthW     = 16;
  localparam int AreaW      = 40;
  localparam int NumW       = 58;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 9;
  localparam logic [15:0] DepthMax = 16'hFF00;

  localparam logic CFG_FB_WIDTH  = 1'b0;
  localparam logic CFG_FB_HEIGHT = 1'b1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic       drawn;
    logic [7:0] shade;
    logic       last;
  } out_item_t;

  // Triangle setup passed from front to back.
  typedef struct packed {
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic signed [AreaW-1:0] area;
    logic [CoordW-1:0] xl, xh, yl, yh;
  } tri_t;

  // Queue entry: one pixel to shade.
  typedef struct packed {
    logic              newtri;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
  } pix_job_t;

endpackage

FILE: rtl/core/trzb_ram.sv
module trzb_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/trzb_front.sv
module trzb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [trzb_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [trzb_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  trzb_pkg::in_item_t           in_data,
  input  logic                         busy,
  output logic                         tri_load,
  output trzb_pkg::tri_t               tri_data,
  output logic                         job_valid,
  input  logic                         job_stall,
  output trzb_pkg::pix_job_t           job
);

  logic [8:0] fbw_r, fbh_r;
  logic [7:0] xl_r, xh_r, yh_r, x_r, y_r;
  logic       act_r, newtri_r;

  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [12:0] fxl, fxh, fyl, fyh;
  logic [8:0]  w_eff, h_eff;
  logic signed [13:0] wlim, hlim;
  logic [7:0]  nxl, nxh, nyl, nyh;
  logic        nact;
  logic signed [16:0] e1x, e1y, e2x, e2y;
  logic signed [trzb_pkg::AreaW-1:0] area;
  logic        accept, is_last, adv_ok;

  always_comb begin
    mnx = in_data.a_x;
    if (in_data.b_x < mnx) mnx = in_data.b_x;
    if (in_data.c_x < mnx) mnx = in_data.c_x;
    mxx = in_data.a_x;
    if (in_data.b_x > mxx) mxx = in_data.b_x;
    if (in_data.c_x > mxx) mxx = in_data.c_x;
    mny = in_data.a_y;
    if (in_data.b_y < mny) mny = in_data.b_y;
    if (in_data.c_y < mny) mny = in_data.c_y;
    mxy = in_data.a_y;
    if (in_data.b_y > mxy) mxy = in_data.b_y;
    if (in_data.c_y > mxy) mxy = in_data.c_y;
    fxl = 13'(mnx >>> 4);
    fxh = 13'(mxx >>> 4);
    fyl = 13'(mny >>> 4);
    fyh = 13'(mxy >>> 4);
    w_eff = (fbw_r == '0) ? 9'd1 : ((fbw_r > 9'(trzb_pkg::MaxWidth)) ?
            9'(trzb_pkg::MaxWidth) : fbw_r);
    h_eff = (fbh_r == '0) ? 9'd1 : ((fbh_r > 9'(trzb_pkg::MaxHeight)) ?
            9'(trzb_pkg::MaxHeight) : fbh_r);
    wlim = $signed({5'd0, w_eff}) - 14'sd1;
    hlim = $signed({5'd0, h_eff}) - 14'sd1;
    nact = 1'b1;
    // clamp and test emptiness in full precision
    if ((14'(fxl) > wlim) || (14'(fyl) > hlim) || (fxh < 13'sd0) || (fyh < 13'sd0)
        || (fxl > fxh) || (fyl > fyh)) begin
      nact = 1'b0;
    end
    nxl = (fxl < 13'sd0) ? 8'd0 : fxl[7:0];
    nyl = (fyl < 13'sd0) ? 8'd0 : fyl[7:0];
    nxh = (14'(fxh) > wlim) ? wlim[7:0] : fxh[7:0];
    nyh = (14'(fyh) > hlim) ? hlim[7:0] : fyh[7:0];
    e1x = 17'(in_data.b_x) - 17'(in_data.a_x);
    e1y = 17'(in_data.c_y) - 17'(in_data.a_y);
    e2x = 17'(in_data.c_x) - 17'(in_data.a_x);
    e2y = 17'(in_data.b_y) - 17'(in_data.a_y);
    area = 40'(e1x * e1y) - 40'(e2x * e2y);
  end

  assign adv_ok   = act_r && !job_stall;
  // loads wait until the back has drained the old triangle
  assign in_stall = (in_data.op == trzb_pkg::OP_LOAD) ? busy : (act_r && job_stall);
  assign accept   = in_valid && !in_stall;
  assign is_last  = (x_r == xh_r) && (y_r == yh_r);

  assign tri_load = accept && (in_data.op == trzb_pkg::OP_LOAD);
  always_comb begin
    tri_data.ax = in_data.a_x; tri_data.ay = in_data.a_y; tri_data.az = in_data.a_z;
    tri_data.bx = in_data.b_x; tri_data.by = in_data.b_y; tri_data.bz = in_data.b_z;
    tri_data.cx = in_data.c_x; tri_data.cy = in_data.c_y; tri_data.cz = in_data.c_z;
    tri_data.area = area;
    tri_data.xl = nxl; tri_data.xh = nxh; tri_data.yl = nyl; tri_data.yh = nyh;
  end

  assign job_valid  = accept && (in_data.op == trzb_pkg::OP_ADVANCE) && act_r;
  assign job.newtri = newtri_r;
  assign job.x      = x_r;
  assign job.y      = y_r;
  assign job.last   = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbw_r <= 9'(trzb_pkg::MaxWidth);
      fbh_r <= 9'(trzb_pkg::MaxHeight);
      act_r <= 1'b0;
      newtri_r <= 1'b0;
      x_r <= '0; y_r <= '0; xl_r <= '0; xh_r <= '0; yh_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          trzb_pkg::CFG_FB_WIDTH:  fbw_r <= cfg_data;
          trzb_pkg::CFG_FB_HEIGHT: fbh_r <= cfg_data;
          default: ;
        endcase
      end
      if (tri_load) begin
        xl_r <= nxl; xh_r <= nxh; yh_r <= nyh;
        x_r <= nxl; y_r <= nyl;
        act_r <= nact;
        newtri_r <= 1'b1;
      end else if (job_valid && adv_ok) begin
        newtri_r <= 1'b0;
        if (is_last) begin
          act_r <= 1'b0;
        end else if (x_r == xh_r) begin
          x_r <= xl_r;
          y_r <= y_r + 8'd1;
        end else begin
          x_r <= x_r + 8'd1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/trzb_queue.sv
module trzb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_stall,
  input  trzb_pkg::pix_job_t  wr_data,
  output logic                rd_valid,
  input  logic                rd_take,
  output trzb_pkg::pix_job_t  rd_data
);

  trzb_pkg::pix_job_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = q_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/core/trzb_back.sv
module trzb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tri_load,
  input  trzb_pkg::tri_t      tri_data,
  input  logic                job_valid,
  output logic                job_take,
  input  trzb_pkg::pix_job_t  job,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output trzb_pkg::out_item_t out_data
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EDGE  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_TEST  = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  st_t st_r;
  trzb_pkg::tri_t t_r;
  logic [trzb_pkg::CoordW-1:0] x_r, y_r;
  logic last_r, inside_r, drawn_r;
  logic signed [35:0] a1_r, a2_r, a3_r;
  logic signed [trzb_pkg::NumW-1:0] num_r;
  logic [trzb_pkg::AreaW-1:0] d_r;
  logic [trzb_pkg::NumW-1:0] mag_r, q_r;
  logic [trzb_pkg::AreaW:0] rem_r;
  logic [5:0] cnt_r;
  logic [7:0] shade_r;
  logic [15:0] z_r;
  logic [trzb_pkg::AddrW-1:0] clr_r;
  logic zload_r;

  logic signed [16:0] px, py;
  logic signed [35:0] a1, a2, a3;
  logic signed [trzb_pkg::NumW-1:0] num;
  logic [trzb_pkg::AreaW:0] rem_sh, rem_sub;
  logic signed [trzb_pkg::NumW:0] zq;
  logic [15:0] zc;
  logic ram_we;
  logic [trzb_pkg::AddrW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;

  function automatic logic signed [35:0] edge_fn(
      input logic signed [16:0] qx, input logic signed [16:0] qy,
      input logic signed [15:0] x2, input logic signed [15:0] y2,
      input logic signed [15:0] x3, input logic signed [15:0] y3);
    logic signed [17:0] dx2, dy3, dx3, dy2;
    begin
      dx2 = 18'(x2) - 18'(qx); dy3 = 18'(y3) - 18'(qy);
      dx3 = 18'(x3) - 18'(qx); dy2 = 18'(y2) - 18'(qy);
      edge_fn = 36'(dx2 * dy3) - 36'(dx3 * dy2);
    end
  endfunction

  always_comb begin
    px = $signed({5'd0, x_r, 4'd0});
    py = $signed({5'd0, y_r, 4'd0});
    a1 = edge_fn(px, py, t_r.bx, t_r.by, t_r.cx, t_r.cy);
    a2 = edge_fn(px, py, t_r.cx, t_r.cy, t_r.ax, t_r.ay);
    a3 = edge_fn(px, py, t_r.ax, t_r.ay, t_r.bx, t_r.by);
    if (t_r.area < 0) begin
      a1 = -a1; a2 = -a2; a3 = -a3;
    end
    num = 58'(a1_r * t_r.az) + 58'(a2_r * t_r.bz) + 58'(a3_r * t_r.cz);
    rem_sh  = {rem_r[trzb_pkg::AreaW-1:0], mag_r[trzb_pkg::NumW-1]};
    rem_sub = rem_sh - {1'b0, d_r};
    // floor division from magnitude quotient
    if (num_r < 0) begin
      zq = -$signed({1'b0, q_r}) - ((rem_r != '0) ? 59'sd1 : 59'sd0);
    end else begin
      zq = $signed({1'b0, q_r});
    end
    zc = (zq > $signed(59'(trzb_pkg::DepthMax))) ? trzb_pkg::DepthMax : zq[15:0];
  end

  assign raddr = {y_r, x_r};
  // z_r holds the clamped depth, zero when negative, so it never beats the store
  assign ram_we = (st_r == S_CLEAR) ||
                  ((st_r == S_TEST) && !zload_r && inside_r && (z_r > rdata));
  assign waddr = (st_r == S_CLEAR) ? clr_r : {y_r, x_r};
  assign wdata = (st_r == S_CLEAR) ? 16'd0 : z_r;

  trzb_ram #(.Width(trzb_pkg::DepthW), .Depth(trzb_pkg::MaxWidth * trzb_pkg::MaxHeight))
    u_depth (.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata),
             .raddr(raddr), .rdata(rdata));

  assign job_take  = (st_r == S_IDLE) && !tri_load;
  assign busy      = (st_r != S_IDLE) || job_valid;
  assign out_valid = (st_r == S_OUT);
  assign out_data  = '{pix_x: x_r, pix_y: y_r, drawn: drawn_r, shade: shade_r,
                       last: last_r};

  always_ff @(posedge clk) begin
    if (tri_load) begin
      t_r <= tri_data;
    end
    case (st_r)
      S_IDLE: if (job_valid && !tri_load) begin
        x_r <= job.x; y_r <= job.y; last_r <= job.last;
      end
      S_EDGE: begin
        a1_r <= a1; a2_r <= a2; a3_r <= a3;
        inside_r <= (t_r.area != '0) && !a1[35] && !a2[35] && !a3[35];
        d_r <= (t_r.area < 0) ? 40'(-t_r.area) : 40'(t_r.area);
      end
      S_MUL: begin
        num_r <= num;
        mag_r <= num[trzb_pkg::NumW-1] ? 58'(-num) : 58'(num);
        rem_r <= '0; q_r <= '0;
      end
      S_DIV: begin
        mag_r <= {mag_r[trzb_pkg::NumW-2:0], 1'b0};
        if (!rem_sub[trzb_pkg::AreaW]) begin
          rem_r <= rem_sub; q_r <= {q_r[trzb_pkg::NumW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;  q_r <= {q_r[trzb_pkg::NumW-2:0], 1'b0};
        end
      end
      S_TEST: begin
        drawn_r <= ram_we;
        shade_r <= ram_we ? z_r[15:8] : 8'd0;
      end
      default: ;
    endcase
    // latch clamped depth when zload_r marks the end of the divider
    if (zload_r) begin
      z_r <= zq[trzb_pkg::NumW] ? 16'h0 : zc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; cnt_r <= '0; zload_r <= 1'b0;
    end else begin
      zload_r <= 1'b0;
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= S_IDLE;
        end
        S_IDLE:  if (job_valid && !tri_load) st_r <= S_EDGE;
        S_EDGE:  st_r <= S_MUL;
        S_MUL: begin
          st_r <= S_DIV;
          cnt_r <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(trzb_pkg::NumW - 1)) begin
            st_r <= S_TEST; zload_r <= 1'b1;
          end
        end
        S_TEST:  if (!zload_r) st_r <= S_OUT;
        S_OUT:   if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/triangle_rasterizer_zbuffer.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  trzb_pkg::in_item_t
// out_      output     out_valid/out_stall trzb_pkg::out_item_t
// cfg_      input      cfg_we             cfg_idx, cfg_data
// Each pixel item runs through the 58-step restoring depth divider.
// A load waits until the back end has drained its pixels.
// After reset the depth memory is cleared before any pixel is shaded.
// Reset is synchronous, active low; out_stall holds the result in place.
module triangle_rasterizer_zbuffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [trzb_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [trzb_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  trzb_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output trzb_pkg::out_item_t           out_data
);

  logic               tri_load, busy, fj_valid, fj_stall, bj_valid, bj_take;
  trzb_pkg::tri_t     tri_data;
  trzb_pkg::pix_job_t fj, bj;

  trzb_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data), .busy(busy),
    .tri_load(tri_load), .tri_data(tri_data),
    .job_valid(fj_valid), .job_stall(fj_stall), .job(fj));

  trzb_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj),
    .rd_valid(bj_valid), .rd_take(bj_take), .rd_data(bj));

  trzb_back u_back (
    .clk(clk), .rst_n(rst_n), .tri_load(tri_load), .tri_data(tri_data),
    .job_valid(bj_valid), .job_take(bj_take), .job(bj), .busy(busy),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

endmodule
